[rtl/plist_pkg.sv]
// package for the positional list engine: request and status codes,
// controller states and the per-cell control struct
// no dependencies
package plist_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed port field widths
  localparam int REQ_W  = 2;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // request codes; the fourth code is unused and reported as out of range
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIND   = 2'd2
  } req_e;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_SCAN   = 2'd2,
    S_RESULT = 2'd3
  } state_e;

  // broadcast control to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
    logic cmp;
  } cell_ctrl_t;

endpackage

[rtl/plist_cell.sv]
// one storage cell of the list chain: holds an item, shifts with its
// neighbors on insert and remove, and flags a match on find
// depends on plist_pkg
module plist_cell #(
  parameter int DATA_WIDTH = plist_pkg::DATA_WIDTH_DEF,
  parameter int PW         = plist_pkg::POS_W,
  parameter int IDX        = 0
) (
  input  logic                   clk_i,
  input  plist_pkg::cell_ctrl_t  ctrl_i,
  input  logic [PW-1:0]          pos_i,
  input  logic [PW-1:0]          count_i,
  input  logic [DATA_WIDTH-1:0]  value_i,
  input  logic [DATA_WIDTH-1:0]  left_i,
  input  logic [DATA_WIDTH-1:0]  right_i,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic                   match_o,
  output logic                   last_o
);

  localparam logic [PW-1:0] MY_POS   = PW'(IDX);
  localparam logic [PW-1:0] NEXT_POS = PW'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  match_q, match_d;
  logic [PW-1:0]         ins_pos;

  // insert position clamped to the end of the list
  assign ins_pos = (pos_i > count_i) ? count_i : pos_i;

  // shift / load selection
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (MY_POS > ins_pos) begin
        data_d = left_i;
      end else if (MY_POS == ins_pos) begin
        data_d = value_i;
      end
    end else if (ctrl_i.rem) begin
      if (MY_POS >= pos_i) begin
        data_d = right_i;
      end
    end
  end

  // match flag, only for cells inside the list
  always_comb begin
    match_d = match_q;
    if (ctrl_i.cmp) begin
      match_d = (MY_POS < count_i) && (data_q == value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;
  assign last_o  = (NEXT_POS == count_i);

endmodule

[rtl/positional_list_engine.sv]
// top level of the positional list engine: controller, chain of cells,
// find scan and result registers
// depends on plist_pkg and plist_cell
//
// channel   direction  handshake               payload
// request   in         start && !busy          req_type_i, item_position_i, item_value_i
// result    out        done_o (one cycle)      status_o, found_position_o, front_item_o,
//                                              back_item_o, item_count_o, list_empty_o
//
// insert and remove pass through exec, where the chain shifts, and result,
// where the result is registered; the strobe is then shown back in idle.
// find adds a scan state between exec and result, where the match flags are
// scanned eight cells per cycle from the front until a hit or the last chunk.
// rst_ni clears the controller and the count; cell contents are not reset.
// the result strobe cannot be stalled; the next request may transfer in the
// cycle the strobe is shown.
module positional_list_engine #(
  parameter int CAPACITY   = plist_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = plist_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [plist_pkg::REQ_W-1:0]   req_type_i,
  input  logic [plist_pkg::POS_W-1:0]   item_position_i,
  input  logic signed [plist_pkg::VAL_W-1:0] item_value_i,
  output logic                          done_o,
  output logic [plist_pkg::STAT_W-1:0]  status_o,
  output logic [plist_pkg::POS_W-1:0]   found_position_o,
  output logic signed [plist_pkg::VAL_W-1:0] front_item_o,
  output logic signed [plist_pkg::VAL_W-1:0] back_item_o,
  output logic [plist_pkg::POS_W-1:0]   item_count_o,
  output logic                          list_empty_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (CNT_W > plist_pkg::POS_W) ? CNT_W : plist_pkg::POS_W;
  localparam int NCH   = (CAPACITY + 7) / 8;
  localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [PW-1:0]   CAP_P    = PW'(CAPACITY);
  localparam logic [CH_W-1:0] LAST_CH  = CH_W'(NCH - 1);

  plist_pkg::state_e     state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [PW-1:0]         count_p;
  logic [plist_pkg::REQ_W-1:0] req_q;
  logic [PW-1:0]         pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [plist_pkg::STAT_W-1:0] status_q;
  logic [PW-1:0]         found_q;
  logic [CH_W-1:0]       chunk_q;
  logic                  done_q;

  plist_pkg::cell_ctrl_t ctrl;
  logic                  accept;
  logic                  do_ins, do_rem, is_find;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  logic [CAPACITY-1:0]   cell_last;
  logic [NCH*8-1:0]      match_pad;
  logic [7:0]            chunk_bits;
  logic                  chunk_hit;
  logic [2:0]            chunk_ffs;

  logic signed [63:0]    val_wide;
  logic [DATA_WIDTH-1:0] back_data;
  logic signed [DATA_WIDTH-1:0] front_s, back_s;
  logic signed [63:0]    front_wide, back_wide;

  assign count_p = PW'(count_q);
  assign accept  = start && !busy;

  // request decode against the current count
  assign do_ins  = (req_q == plist_pkg::REQ_INSERT) && (count_p < CAP_P);
  assign do_rem  = (req_q == plist_pkg::REQ_REMOVE) && (pos_q < count_p);
  assign is_find = (req_q == plist_pkg::REQ_FIND);

  // value brought to the cell width
  assign val_wide = 64'(item_value_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      plist_pkg::S_IDLE: begin
        if (start) state_d = plist_pkg::S_EXEC;
      end
      plist_pkg::S_EXEC: begin
        state_d = is_find ? plist_pkg::S_SCAN : plist_pkg::S_RESULT;
      end
      plist_pkg::S_SCAN: begin
        if (chunk_hit || (chunk_q == LAST_CH)) state_d = plist_pkg::S_RESULT;
      end
      plist_pkg::S_RESULT: begin
        state_d = plist_pkg::S_IDLE;
      end
      default: state_d = plist_pkg::S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    busy = 1'b1;
    ctrl = '0;
    case (state_q)
      plist_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      plist_pkg::S_EXEC: begin
        ctrl.ins = do_ins;
        ctrl.rem = do_rem;
        ctrl.cmp = is_find;
      end
      plist_pkg::S_SCAN:   ;
      plist_pkg::S_RESULT: ;
      default:             ;
    endcase
  end

  // count update
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plist_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_q == plist_pkg::S_RESULT);
    end
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data;
    if (i == 0) begin : g_head
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end
    plist_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW),
      .IDX        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_q),
      .count_i (count_p),
      .value_i (val_q),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i]),
      .last_o  (cell_last[i])
    );
  end

  // find scan, eight match flags per cycle
  assign match_pad  = (NCH*8)'(cell_match);
  assign chunk_bits = match_pad[chunk_q*8 +: 8];
  assign chunk_hit  = |chunk_bits;

  always_comb begin
    chunk_ffs = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (chunk_bits[b]) chunk_ffs = 3'(b);
    end
  end

  // back item: and-or over the one cell flagged as last
  always_comb begin
    back_data = '0;
    for (int c = 0; c < CAPACITY; c++) begin
      back_data = back_data | (cell_data[c] & {DATA_WIDTH{cell_last[c]}});
    end
  end

  assign front_s    = (count_q == '0) ? '0 : cell_data[0];
  assign back_s     = back_data;
  assign front_wide = 64'(front_s);
  assign back_wide  = 64'(back_s);

  // request latch, status, scan position and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      pos_q <= PW'(item_position_i);
      val_q <= val_wide[DATA_WIDTH-1:0];
    end
    if (state_q == plist_pkg::S_EXEC) begin
      found_q <= '0;
      chunk_q <= '0;
      if (req_q == plist_pkg::REQ_INSERT) begin
        status_q <= do_ins ? plist_pkg::ST_OK : plist_pkg::ST_FULL;
      end else if (req_q == plist_pkg::REQ_REMOVE) begin
        status_q <= do_rem ? plist_pkg::ST_OK : plist_pkg::ST_RANGE;
      end else if (is_find) begin
        status_q <= plist_pkg::ST_OK;
      end else begin
        status_q <= plist_pkg::ST_RANGE;
      end
    end
    if (state_q == plist_pkg::S_SCAN) begin
      chunk_q <= chunk_q + CH_W'(1);
      if (chunk_hit) begin
        found_q <= PW'({chunk_q, chunk_ffs});
      end else if (chunk_q == LAST_CH) begin
        found_q <= count_p;
      end
    end
    if (state_q == plist_pkg::S_RESULT) begin
      status_o         <= status_q;
      found_position_o <= plist_pkg::POS_W'(found_q);
      front_item_o     <= front_wide[plist_pkg::VAL_W-1:0];
      back_item_o      <= back_wide[plist_pkg::VAL_W-1:0];
      item_count_o     <= plist_pkg::POS_W'(count_q);
      list_empty_o     <= (count_q == '0);
    end
  end

  assign done_o = done_q;

  // checks
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("request transfer did not start work");

  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(count_q) <= CAP_P)
    else $error("item count beyond capacity");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the positional list engine: a scoreboard class
// keeps its own list and predicts every result, plain tasks drive requests
// depends on plist_pkg and positional_list_engine

// one predicted or observed result transfer
typedef struct packed {
  logic [plist_pkg::STAT_W-1:0] status;
  logic [plist_pkg::POS_W-1:0]  found_pos;
  logic [plist_pkg::VAL_W-1:0]  front;
  logic [plist_pkg::VAL_W-1:0]  back;
  logic [plist_pkg::POS_W-1:0]  count;
  logic                         is_empty;
} list_result_t;

class list_scoreboard;
  logic [plist_pkg::VAL_W-1:0] cells [plist_pkg::CAPACITY_DEF];
  int unsigned      fill;
  list_result_t     pending [$];
  int unsigned      errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  // update the shadow list for an accepted request and queue its result
  function void note_request(logic [plist_pkg::REQ_W-1:0] req,
                             logic [plist_pkg::POS_W-1:0] pos,
                             logic [plist_pkg::VAL_W-1:0] val);
    list_result_t exp;
    int unsigned  p;
    exp        = '0;
    exp.status = plist_pkg::ST_OK;
    p          = 32'(pos);
    case (req)
      plist_pkg::REQ_INSERT: begin
        if (fill >= plist_pkg::CAPACITY_DEF) begin
          exp.status = plist_pkg::ST_FULL;
        end else begin
          if (p > fill) p = fill;
          for (int i = fill; i > p; i--) cells[i] = cells[i-1];
          cells[p] = val;
          fill++;
        end
      end
      plist_pkg::REQ_REMOVE: begin
        if (p >= fill) begin
          exp.status = plist_pkg::ST_RANGE;
        end else begin
          for (int i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
          fill--;
        end
      end
      plist_pkg::REQ_FIND: begin
        exp.found_pos = fill[plist_pkg::POS_W-1:0];
        for (int i = fill - 1; i >= 0; i--) begin
          if (cells[i] == val) exp.found_pos = i[plist_pkg::POS_W-1:0];
        end
      end
      default: begin
        exp.status = plist_pkg::ST_RANGE;
      end
    endcase
    if (fill != 0) begin
      exp.front = cells[0];
      exp.back  = cells[fill-1];
    end
    exp.count    = fill[plist_pkg::POS_W-1:0];
    exp.is_empty = (fill == 0);
    pending.insert(pending.size(), exp);
  endfunction

  // compare one result transfer with the oldest prediction
  function void check_result(list_result_t got);
    list_result_t exp;
    if (pending.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    exp = pending[0];
    pending.delete(0);
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      errors++;
    end
    if (got.found_pos !== exp.found_pos) begin
      $error("found_position: expected %0d, got %0d", exp.found_pos, got.found_pos);
      errors++;
    end
    if (got.front !== exp.front) begin
      $error("front_item: expected %h, got %h", exp.front, got.front);
      errors++;
    end
    if (got.back !== exp.back) begin
      $error("back_item: expected %h, got %h", exp.back, got.back);
      errors++;
    end
    if (got.count !== exp.count) begin
      $error("item_count: expected %0d, got %0d", exp.count, got.count);
      errors++;
    end
    if (got.is_empty !== exp.is_empty) begin
      $error("list_empty: expected %0b, got %0b", exp.is_empty, got.is_empty);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam logic [plist_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned      CYCLE_LIMIT = 200000;
  localparam int unsigned      NUM_RANDOM  = 850;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  logic [plist_pkg::REQ_W-1:0]         req_type_i;
  logic [plist_pkg::POS_W-1:0]         item_position_i;
  logic signed [plist_pkg::VAL_W-1:0]  item_value_i;
  logic                                done_o;
  logic [plist_pkg::STAT_W-1:0]        status_o;
  logic [plist_pkg::POS_W-1:0]         found_position_o;
  logic signed [plist_pkg::VAL_W-1:0]  front_item_o;
  logic signed [plist_pkg::VAL_W-1:0]  back_item_o;
  logic [plist_pkg::POS_W-1:0]         item_count_o;
  logic                                list_empty_o;

  list_scoreboard sb = new();
  int unsigned    cycles = 0;

  positional_list_engine dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .item_position_i  (item_position_i),
    .item_value_i     (item_value_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .front_item_o     (front_item_o),
    .back_item_o      (back_item_o),
    .item_count_o     (item_count_o),
    .list_empty_o     (list_empty_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    list_result_t seen;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      seen.status    = status_o;
      seen.found_pos = found_position_o;
      seen.front     = front_item_o;
      seen.back      = back_item_o;
      seen.count     = item_count_o;
      seen.is_empty  = list_empty_o;
      sb.check_result(seen);
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // present one request from a falling edge and hold it until it transfers
  task automatic send_request(logic [plist_pkg::REQ_W-1:0] req,
                              logic [plist_pkg::POS_W-1:0] pos,
                              logic [plist_pkg::VAL_W-1:0] val);
    start           = 1'b1;
    req_type_i      = req;
    item_position_i = pos;
    item_value_i    = val;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    sb.note_request(req, pos, val);
    @(negedge clk_i);
  endtask

  // sender gap with noise on the request fields
  task automatic idle_for(int unsigned n);
    start           = 1'b0;
    req_type_i      = plist_pkg::REQ_W'($urandom);
    item_position_i = plist_pkg::POS_W'($urandom);
    item_value_i    = $urandom;
    repeat (n) @(negedge clk_i);
  endtask

  // value mix: extremes, a narrow band for duplicates, full random
  function automatic logic [plist_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0000_0000;
      3, 4:    return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // one random request; mode steers the list toward growing, shrinking or searching
  task automatic send_random(int unsigned mode);
    int unsigned      ins_pct;
    int unsigned      rem_pct;
    int unsigned      find_pct;
    int unsigned      roll;
    logic [plist_pkg::REQ_W-1:0] req;
    logic [plist_pkg::POS_W-1:0] pos;
    logic [plist_pkg::VAL_W-1:0] val;
    case (mode)
      0:       begin ins_pct = 70; rem_pct = 15; find_pct = 12; end
      1:       begin ins_pct = 20; rem_pct = 65; find_pct = 12; end
      default: begin ins_pct = 30; rem_pct = 27; find_pct = 40; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct)                            req = plist_pkg::REQ_INSERT;
    else if (roll < ins_pct + rem_pct)             req = plist_pkg::REQ_REMOVE;
    else if (roll < ins_pct + rem_pct + find_pct)  req = plist_pkg::REQ_FIND;
    else                                           req = REQ_UNUSED;
    // positions mostly inside the list, sometimes anywhere in the field
    if ($urandom_range(0, 4) == 0)
      pos = plist_pkg::POS_W'($urandom_range(0, 31));
    else if (req == plist_pkg::REQ_REMOVE && sb.fill != 0)
      pos = plist_pkg::POS_W'($urandom_range(0, sb.fill - 1));
    else
      pos = plist_pkg::POS_W'($urandom_range(0, sb.fill));
    if (req == plist_pkg::REQ_FIND && sb.fill != 0 && $urandom_range(0, 1) != 0)
      val = sb.cells[$urandom_range(0, sb.fill - 1)];
    else
      val = pick_value();
    send_request(req, pos, val);
  endtask

  initial begin
    int unsigned sent;
    int unsigned mode;
    int unsigned burst;
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = '0;
    item_position_i = '0;
    item_value_i    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty list cases
    send_request(plist_pkg::REQ_REMOVE, 5'd0, 32'h0);
    send_request(plist_pkg::REQ_FIND, 5'd0, 32'h0);
    send_request(REQ_UNUSED, 5'd31, 32'hffff_ffff);
    // inserts with extreme values, clamped past the end
    send_request(plist_pkg::REQ_INSERT, 5'd31, 32'h8000_0000);
    send_request(plist_pkg::REQ_INSERT, 5'd0, 32'h7fff_ffff);
    send_request(plist_pkg::REQ_INSERT, 5'd1, 32'hffff_ffff);
    send_request(plist_pkg::REQ_INSERT, 5'd16, 32'h0000_0000);
    send_request(plist_pkg::REQ_INSERT, 5'd2, 32'hffff_ffff);
    // find: present, duplicate, absent
    send_request(plist_pkg::REQ_FIND, 5'd31, 32'h8000_0000);
    send_request(plist_pkg::REQ_FIND, 5'd0, 32'hffff_ffff);
    send_request(plist_pkg::REQ_FIND, 5'd0, 32'h0001_2345);
    // remove past the end, at the count, at the back and at the front
    send_request(plist_pkg::REQ_REMOVE, 5'd31, 32'h0);
    send_request(plist_pkg::REQ_REMOVE, 5'd5, 32'h0);
    send_request(plist_pkg::REQ_REMOVE, 5'd4, 32'h0);
    send_request(plist_pkg::REQ_REMOVE, 5'd0, 32'h0);
    send_request(REQ_UNUSED, 5'd1, 32'h0);
    // fill to capacity, then insert into the full list
    while (sb.fill < plist_pkg::CAPACITY_DEF)
      send_request(plist_pkg::REQ_INSERT, plist_pkg::POS_W'($urandom), $urandom);
    send_request(plist_pkg::REQ_INSERT, 5'd0, 32'h5555_aaaa);
    send_request(plist_pkg::REQ_FIND, 5'd0, sb.cells[plist_pkg::CAPACITY_DEF-1]);
    send_request(plist_pkg::REQ_REMOVE, 5'd16, 32'h0);
    send_request(plist_pkg::REQ_REMOVE, 5'd15, 32'h0);

    // random bursts with random gaps
    sent = 0;
    mode = 2;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 3) == 0) mode = $urandom_range(0, 2);
      repeat (burst) begin
        send_random(mode);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) idle_for(0);
      else                            idle_for($urandom_range(1, 12));
    end
    start = 1'b0;

    // drain
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
